>>> src/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants and types of the matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // sizes of the problem
  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = $clog2(MaxRows);

  // register and data widths
  localparam int LenW   = 11;
  localparam int WordW  = 32;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  // register map
  localparam logic RegOutLen = 1'b0;
  localparam logic RegInLen  = 1'b1;

  // item modes
  localparam logic ModePreload = 1'b0;
  localparam logic ModeWeight  = 1'b1;

  // depth of the fused multiply-add pipeline
  localparam int FmaStages = 7;

  // signed exponent width inside the datapath
  localparam int ExpW = 12;

  // single-precision codes
  localparam logic [30:0] InfMag  = 31'h7F80_0000;
  localparam logic [31:0] QNan    = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;

  // per-item control carried alongside the datapath
  typedef struct packed {
    logic            valid;
    logic            preload;
    logic            emit;
    logic            last;
    logic [ColW-1:0] col;
  } mvm_tag_t;

  // configuration seen by the core
  typedef struct packed {
    logic [LenW-1:0] out_len;
    logic [LenW-1:0] in_len;
    logic            wr;
  } mvm_cfg_t;

endpackage

>>> src/mvm_stream_if.sv
// ----------------------------------------------------------------------------
// mvm stream interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface mvm_in_if import mvm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [WordW-1:0] weight;
  logic [WordW-1:0] input_value;

  modport source(output valid, mode, weight, input_value, input ready);
  modport sink(input valid, mode, weight, input_value, output ready);
endinterface

interface mvm_out_if import mvm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ColW-1:0]  column;
  logic [WordW-1:0] sum;
  logic             last;

  modport source(output valid, column, sum, last, input ready);
  modport sink(input valid, column, sum, last, output ready);
endinterface

>>> src/matrix_vector_mac.sv
// ----------------------------------------------------------------------------
// matrix_vector_mac
// Single-precision matrix-vector multiply-accumulate over an accumulator RAM.
// ----------------------------------------------------------------------------
// Preload words seed the column accumulators in order; weight words then
// arrive row by row and each does a fused multiply-add into its column's
// accumulator, held in a 1024-entry RAM read as a word is accepted, ahead
// of the seven-stage FMA pipeline, and written back from its last stage. A
// word is accepted every cycle while its column is not in the pipeline and
// a result held for the output does not stall it: one word per cycle for
// out_len of 8 or more; below that a word waits for its column's write-back.
// A finished column moves from the last stage to the output register, which
// lets accepting go on while a result waits. Reset needs no RAM clearing pass.
// ----------------------------------------------------------------------------
module matrix_vector_mac import mvm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  mvm_in_if.sink           in_i,
  mvm_out_if.source        out_o
);

  mvm_cfg_t cfg;

  mvm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // effective lengths
  logic [LenW:0] cols, rows;

  always_comb begin
    if (cfg.out_len == '0) cols = (LenW+1)'(1);
    else if (32'(cfg.out_len) > MaxColumns) cols = (LenW+1)'(MaxColumns);
    else cols = (LenW+1)'(cfg.out_len);
    if (cfg.in_len == '0) rows = (LenW+1)'(1);
    else if (32'(cfg.in_len) > MaxRows) rows = (LenW+1)'(MaxRows);
    else rows = (LenW+1)'(cfg.in_len);
  end

  // position counters
  logic [ColW-1:0] col_q, col_d, col;
  logic [RowW-1:0] row_q, row_d, row;
  logic            col_last, row_last;

  assign col      = (32'(col_q) >= 32'(cols)) ? '0 : col_q;
  assign row      = (32'(row_q) >= 32'(rows)) ? '0 : row_q;
  assign col_last = (32'(col) + 32'd1) >= 32'(cols);
  assign row_last = (32'(row) + 32'd1) >= 32'(rows);

  // pipeline control
  mvm_tag_t         tags [FmaStages];
  mvm_tag_t         in_tag;
  logic             adv, hazard, accept;
  logic [WordW-1:0] acc_rdata, fma_res;
  logic             out_v_q;
  logic [ColW-1:0]  out_col_q;
  logic [WordW-1:0] out_sum_q;
  logic             out_last_q;

  // a column still in flight must be written back before it is read again
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < FmaStages; i++) begin
      if (tags[i].valid && tags[i].col == col) hazard = 1'b1;
    end
  end

  assign adv    = !(tags[FmaStages-1].valid && tags[FmaStages-1].emit &&
                    out_v_q && !out_o.ready);
  assign in_i.ready = adv & ~hazard;
  assign accept = in_i.valid & in_i.ready;

  assign in_tag.valid   = accept;
  assign in_tag.preload = (in_i.mode == ModePreload);
  assign in_tag.emit    = (in_i.mode == ModeWeight) & row_last;
  assign in_tag.last    = col_last;
  assign in_tag.col     = col;

  // counter advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg.wr) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (in_i.mode == ModePreload) begin
        row_d = '0;
        col_d = col_last ? '0 : col + ColW'(1);
      end else if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row + RowW'(1);
      end else begin
        col_d = col + ColW'(1);
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // accumulator memory
  mvm_acc_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (adv),
    .raddr_i (col),
    .rdata_o (acc_rdata),
    .we_i    (adv & tags[FmaStages-1].valid),
    .waddr_i (tags[FmaStages-1].col),
    .wdata_i (fma_res)
  );

  // multiply-add datapath
  mvm_fma_pipe u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tag_i  (in_tag),
    .a_i    (in_i.weight),
    .b_i    (in_i.input_value),
    .c_i    (acc_rdata),
    .tags_o (tags),
    .res_o  (fma_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && tags[FmaStages-1].valid && tags[FmaStages-1].emit) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tags[FmaStages-1].valid && tags[FmaStages-1].emit) begin
      out_col_q  <= tags[FmaStages-1].col;
      out_sum_q  <= fma_res;
      out_last_q <= tags[FmaStages-1].last;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.column = out_col_q;
  assign out_o.sum    = out_sum_q;
  assign out_o.last   = out_last_q;

endmodule

>>> src/mvm_cfg.sv
// ----------------------------------------------------------------------------
// mvm_cfg
// APB register file holding the output and input lengths.
// ----------------------------------------------------------------------------
module mvm_cfg import mvm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output logic             pready_o,
  output mvm_cfg_t         cfg_o
);

  logic [LenW-1:0] out_len_q, out_len_d;
  logic [LenW-1:0] in_len_q, in_len_d;
  logic            wr;

  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  // register writes
  always_comb begin
    out_len_d = out_len_q;
    in_len_d  = in_len_q;
    if (wr) begin
      unique case (paddr_i[2])
        RegOutLen: out_len_d = pwdata_i[LenW-1:0];
        RegInLen:  in_len_d  = pwdata_i[LenW-1:0];
        default:   out_len_d = out_len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= LenW'(1);
      in_len_q  <= LenW'(1);
    end else begin
      out_len_q <= out_len_d;
      in_len_q  <= in_len_d;
    end
  end

  // read back
  always_comb begin
    unique case (paddr_i[2])
      RegOutLen: prdata_o = DataW'(out_len_q);
      RegInLen:  prdata_o = DataW'(in_len_q);
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o.out_len = out_len_q;
  assign cfg_o.in_len  = in_len_q;
  assign cfg_o.wr      = wr;

endmodule

>>> src/mvm_acc_ram.sv
// ----------------------------------------------------------------------------
// mvm_acc_ram
// Accumulator memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvm_acc_ram import mvm_pkg::*; (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [ColW-1:0]  raddr_i,
  output logic [WordW-1:0] rdata_o,
  input  logic             we_i,
  input  logic [ColW-1:0]  waddr_i,
  input  logic [WordW-1:0] wdata_i
);

  logic [WordW-1:0] mem [MaxColumns];
  logic [WordW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mvm_fma_pipe.sv
// ----------------------------------------------------------------------------
// mvm_fma_pipe
// Seven-stage single-precision fused multiply-add, rounded once to nearest
// even, with a control tag riding along each stage.
// ----------------------------------------------------------------------------
module mvm_fma_pipe import mvm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  mvm_tag_t         tag_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  input  logic [WordW-1:0] c_i,
  output mvm_tag_t         tags_o [FmaStages],
  output logic [WordW-1:0] res_o
);

  // leading zeros of a 24-bit mantissa
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] lz;
    lz = '0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  // position of the top set bit of a 64-bit word
  function automatic logic [5:0] top64(input logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // right shift keeping a sticky bit at the bottom
  function automatic logic [63:0] shr_sticky(input logic [63:0] m, input logic [ExpW-1:0] amt);
    logic [127:0] t;
    logic [63:0]  r;
    t = {m, 64'b0} >> amt[5:0];
    if (amt >= ExpW'(64)) r = {63'b0, |m};
    else r = t[127:64] | {63'b0, |t[63:0]};
    return r;
  endfunction

  mvm_tag_t tag_q [FmaStages];

  // tags move with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FmaStages; i++) tag_q[i] <= '0;
    end else if (adv_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < FmaStages; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  assign tags_o = tag_q;

  // ---------------- stage 1: operands, specials, normalize ----------------
  logic [WordW-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_a_q <= a_i;
      s1_b_q <= b_i;
    end
  end

  logic        sa, sb, sc, sp;
  logic [7:0]  ea, eb, ec;
  logic [30:0] am, bm, cm;
  logic        nan_a, nan_b, nan_c;
  logic        s1_spec;
  logic [31:0] s1_sval;
  logic [23:0] ma_n, mb_n, mc_n, ma_r, mb_r, mc_r;
  logic [4:0]  lz_a, lz_b, lz_c;
  logic signed [ExpW-1:0] ea_n, eb_n, ec_n;

  assign sa = s1_a_q[31];
  assign sb = s1_b_q[31];
  assign sc = c_i[31];
  assign sp = sa ^ sb;
  assign ea = s1_a_q[30:23];
  assign eb = s1_b_q[30:23];
  assign ec = c_i[30:23];
  assign am = s1_a_q[30:0];
  assign bm = s1_b_q[30:0];
  assign cm = c_i[30:0];
  assign nan_a = am > InfMag;
  assign nan_b = bm > InfMag;
  assign nan_c = cm > InfMag;

  // special results bypass the arithmetic
  always_comb begin
    s1_spec = 1'b1;
    s1_sval = '0;
    priority if (tag_q[0].preload) begin
      s1_sval = s1_a_q;
    end else if (nan_a) begin
      s1_sval = s1_a_q | QuietBit;
    end else if (nan_b) begin
      s1_sval = s1_b_q | QuietBit;
    end else if (nan_c) begin
      s1_sval = c_i | QuietBit;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if (am == '0 || bm == '0) s1_sval = QNan;
      else if (ec == 8'hFF && sc != sp) s1_sval = QNan;
      else s1_sval = {sp, InfMag};
    end else if (ec == 8'hFF) begin
      s1_sval = c_i;
    end else if (am == '0 || bm == '0) begin
      if (cm != '0) s1_sval = c_i;
      else s1_sval = {sp & sc, 31'b0};
    end else begin
      s1_spec = 1'b0;
    end
  end

  // mantissas brought to a leading one at bit 23
  assign ma_r = {ea != 8'h00, s1_a_q[22:0]};
  assign mb_r = {eb != 8'h00, s1_b_q[22:0]};
  assign mc_r = {ec != 8'h00, c_i[22:0]};
  assign lz_a = lzc24(ma_r);
  assign lz_b = lzc24(mb_r);
  assign lz_c = lzc24(mc_r);
  assign ma_n = ma_r << lz_a;
  assign mb_n = mb_r << lz_b;
  assign mc_n = mc_r << lz_c;
  assign ea_n = $signed(ExpW'((ea == 8'h00) ? 8'h01 : ea)) - $signed(ExpW'(lz_a));
  assign eb_n = $signed(ExpW'((eb == 8'h00) ? 8'h01 : eb)) - $signed(ExpW'(lz_b));
  assign ec_n = $signed(ExpW'((ec == 8'h00) ? 8'h01 : ec)) - $signed(ExpW'(lz_c));

  // ---------------- stage 2: multiply ----------------
  logic [23:0] s2_ma_q, s2_mb_q, s2_mc_q;
  logic signed [ExpW-1:0] s2_ea_q, s2_eb_q, s2_ec_q;
  logic        s2_sp_q, s2_sc_q, s2_cz_q, s2_spec_q;
  logic [31:0] s2_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_ma_q   <= ma_n;
      s2_mb_q   <= mb_n;
      s2_mc_q   <= mc_n;
      s2_ea_q   <= ea_n;
      s2_eb_q   <= eb_n;
      s2_ec_q   <= ec_n;
      s2_sp_q   <= sp;
      s2_sc_q   <= sc;
      s2_cz_q   <= (cm == '0);
      s2_spec_q <= s1_spec;
      s2_sval_q <= s1_sval;
    end
  end

  logic [47:0] s2_mp;
  logic signed [ExpW-1:0] s2_ep;

  assign s2_mp = s2_ma_q * s2_mb_q;
  assign s2_ep = s2_ea_q + s2_eb_q - ExpW'(300);

  // ---------------- stage 3: align ----------------
  logic [47:0] s3_mp_q;
  logic [23:0] s3_mc_q;
  logic signed [ExpW-1:0] s3_ep_q, s3_ec_q;
  logic        s3_sp_q, s3_sc_q, s3_cz_q, s3_spec_q;
  logic [31:0] s3_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_mp_q   <= s2_mp;
      s3_mc_q   <= s2_mc_q;
      s3_ep_q   <= s2_ep;
      s3_ec_q   <= s2_ec_q;
      s3_sp_q   <= s2_sp_q;
      s3_sc_q   <= s2_sc_q;
      s3_cz_q   <= s2_cz_q;
      s3_spec_q <= s2_spec_q;
      s3_sval_q <= s2_sval_q;
    end
  end

  logic [63:0] s3_p, s3_c, s3_pal, s3_cal;
  logic signed [ExpW-1:0] s3_ep, s3_ec, s3_d, s3_e;

  // both leading ones placed at bit 61
  always_comb begin
    if (s3_mp_q[47]) begin
      s3_p  = {2'b0, s3_mp_q, 14'b0};
      s3_ep = s3_ep_q - ExpW'(14);
    end else begin
      s3_p  = {1'b0, s3_mp_q, 15'b0};
      s3_ep = s3_ep_q - ExpW'(15);
    end
    s3_c  = {2'b0, s3_mc_q, 38'b0};
    s3_ec = s3_ec_q - ExpW'(188);
    s3_d  = s3_ep - s3_ec;
    if (s3_cz_q) begin
      s3_pal = s3_p;
      s3_cal = '0;
      s3_e   = s3_ep;
    end else if (s3_d >= 0) begin
      s3_pal = s3_p;
      s3_cal = shr_sticky(s3_c, s3_d);
      s3_e   = s3_ep;
    end else begin
      s3_pal = shr_sticky(s3_p, -s3_d);
      s3_cal = s3_c;
      s3_e   = s3_ec;
    end
  end

  // ---------------- stage 4: add ----------------
  logic [63:0] s4_p_q, s4_c_q;
  logic signed [ExpW-1:0] s4_e_q;
  logic        s4_sp_q, s4_sc_q, s4_spec_q;
  logic [31:0] s4_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_p_q    <= s3_pal;
      s4_c_q    <= s3_cal;
      s4_e_q    <= s3_e;
      s4_sp_q   <= s3_sp_q;
      s4_sc_q   <= s3_sc_q;
      s4_spec_q <= s3_spec_q;
      s4_sval_q <= s3_sval_q;
    end
  end

  logic [64:0] s4_d1, s4_d2;
  logic [63:0] s4_sum;
  logic        s4_sign, s4_spec;
  logic [31:0] s4_sval;

  assign s4_d1 = {1'b0, s4_p_q} - {1'b0, s4_c_q};
  assign s4_d2 = {1'b0, s4_c_q} - {1'b0, s4_p_q};

  // magnitude add or subtract, exact cancellation gives +0
  always_comb begin
    s4_spec = s4_spec_q;
    s4_sval = s4_sval_q;
    if (s4_sp_q == s4_sc_q) begin
      s4_sum  = s4_p_q + s4_c_q;
      s4_sign = s4_sp_q;
    end else if (!s4_d1[64]) begin
      s4_sum  = s4_d1[63:0];
      s4_sign = s4_sp_q;
    end else begin
      s4_sum  = s4_d2[63:0];
      s4_sign = s4_sc_q;
    end
    if (!s4_spec_q && s4_sp_q != s4_sc_q && s4_p_q == s4_c_q) begin
      s4_spec = 1'b1;
      s4_sval = '0;
    end
  end

  // ---------------- stage 5: find the leading one ----------------
  logic [63:0] s5_sum_q;
  logic signed [ExpW-1:0] s5_e_q;
  logic        s5_sign_q, s5_spec_q;
  logic [31:0] s5_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_sum_q  <= s4_sum;
      s5_e_q    <= s4_e_q;
      s5_sign_q <= s4_sign;
      s5_spec_q <= s4_spec;
      s5_sval_q <= s4_sval;
    end
  end

  logic signed [ExpW-1:0] s5_tgt, s5_tgt_raw, s5_sh;

  assign s5_tgt_raw = $signed(ExpW'(top64(s5_sum_q))) + s5_e_q - ExpW'(23);
  assign s5_tgt     = (s5_tgt_raw < -ExpW'(149)) ? -ExpW'(149) : s5_tgt_raw;
  assign s5_sh      = s5_tgt - s5_e_q;

  // ---------------- stage 6: shift to 24 bits ----------------
  logic [63:0] s6_sum_q;
  logic signed [ExpW-1:0] s6_sh_q, s6_tgt_q;
  logic        s6_sign_q, s6_spec_q;
  logic [31:0] s6_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s6_sum_q  <= s5_sum_q;
      s6_sh_q   <= s5_sh;
      s6_tgt_q  <= s5_tgt;
      s6_sign_q <= s5_sign_q;
      s6_spec_q <= s5_spec_q;
      s6_sval_q <= s5_sval_q;
    end
  end

  logic [23:0]  s6_q;
  logic         s6_rnd, s6_stk;
  logic [127:0] s6_t;
  logic [63:0]  s6_l;
  logic [ExpW-1:0] s6_nsh;
  logic [6:0]   s6_amt;

  always_comb begin
    s6_nsh = -s6_sh_q;
    s6_amt = (s6_sh_q > ExpW'(127)) ? 7'd127 : s6_sh_q[6:0];
    s6_t   = {s6_sum_q, 64'b0} >> s6_amt;
    s6_l   = s6_sum_q << s6_nsh[4:0];
    if (s6_sh_q < 0) begin
      s6_q   = s6_l[23:0];
      s6_rnd = 1'b0;
      s6_stk = 1'b0;
    end else begin
      s6_q   = s6_t[87:64];
      s6_rnd = s6_t[63];
      s6_stk = |s6_t[62:0];
    end
  end

  // ---------------- stage 7: round and pack ----------------
  logic [23:0] s7_q_q;
  logic        s7_rnd_q, s7_stk_q, s7_sign_q, s7_spec_q;
  logic signed [ExpW-1:0] s7_tgt_q;
  logic [31:0] s7_sval_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s7_q_q    <= s6_q;
      s7_rnd_q  <= s6_rnd;
      s7_stk_q  <= s6_stk;
      s7_tgt_q  <= s6_tgt_q;
      s7_sign_q <= s6_sign_q;
      s7_spec_q <= s6_spec_q;
      s7_sval_q <= s6_sval_q;
    end
  end

  logic [24:0] s7_q2;
  logic signed [ExpW-1:0] s7_tgt, s7_bexp;
  logic [31:0] s7_res;

  always_comb begin
    s7_q2  = {1'b0, s7_q_q} + 25'(s7_rnd_q & (s7_stk_q | s7_q_q[0]));
    s7_tgt = s7_tgt_q;
    if (s7_q2[24]) begin
      s7_q2  = s7_q2 >> 1;
      s7_tgt = s7_tgt_q + ExpW'(1);
    end
    s7_bexp = s7_tgt + ExpW'(150);
    if (!s7_q2[23]) s7_res = {s7_sign_q, 8'h00, s7_q2[22:0]};
    else if (s7_bexp >= ExpW'(255)) s7_res = {s7_sign_q, InfMag};
    else s7_res = {s7_sign_q, s7_bexp[7:0], s7_q2[22:0]};
  end

  assign res_o = s7_spec_q ? s7_sval_q : s7_res;

endmodule
